[rtl/source_text_tokenizer_core_defines.svh]
// Assertion macros for the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define STTK_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger, outside reset.
`define STTK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sttk_pkg.sv]
package sttk_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int MAX_LINE      = 65535;
   localparam int MAX_COLUMN    = 65535;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_FF_END = 8'hFF;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FEED   = 8'h0C;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_NUMBER  = 2'd1,
      MODE_IDENT   = 2'd2,
      MODE_COMMENT = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      KIND_END    = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_IDENT  = 4'd2,
      KIND_LPAREN = 4'd3,
      KIND_RPAREN = 4'd4,
      KIND_LBRACE = 4'd5,
      KIND_RBRACE = 4'd6,
      KIND_PLUS   = 4'd7,
      KIND_MINUS  = 4'd8,
      KIND_DIVIDE = 4'd9,
      KIND_TIMES  = 4'd10,
      KIND_COMMA  = 4'd11,
      KIND_ERROR  = 4'd12
   } kind_type;

   typedef enum logic [2:0] {
      CAUSE_NONE        = 3'd0,
      CAUSE_BAD_START   = 3'd1,
      CAUSE_BAD_NUMBER  = 3'd2,
      CAUSE_SECOND_PT   = 3'd3,
      CAUSE_BAD_IDENT   = 3'd4
   } cause_type;

   typedef struct packed {
      kind_type    kind;
      cause_type   cause;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  length;
      logic        last;
   } rsp_type;

endpackage

[rtl/source_text_tokenizer_core.sv]
// A result is written to the queue when the byte that causes it is transferred.
// Throughput: one byte per cycle while req_ready is high; a byte that causes two
// results needs two output transfers, absorbed by a four-entry result queue that
// holds req_ready low when fewer than two entries are free.
// Reset (synchronous, active high) empties the queue and returns the scanner to
// idle at line 1, column 1.
module source_text_tokenizer_core
   import sttk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_cause,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_last_of_run
);

`include "source_text_tokenizer_core_defines.svh"

   // Scanner state. The column register always holds the column of the next byte.
   mode_type    mode_ff,  mode_in;
   logic [15:0] line_ff,  line_in;
   logic [15:0] col_ff,   col_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  len_ff,   len_in;
   logic        pt_ff,    pt_in;

   // Result queue. Every byte is scanned in the cycle it is transferred and its
   // results land in the queue, which is the output register of the block.
   rsp_type            q_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic c_digit, c_letter, c_blank, c_end, c_nl, c_colon, c_point, c_under;
   logic c_op, c_stop, c_word;
   kind_type    single_kind;
   logic        single_hit;

   logic [15:0] col_adv;
   logic [15:0] line_adv;
   logic [7:0]  len_grow;

   logic    do_idle;
   logic    r0_v, r1_v, ir_v;
   rsp_type r0, r1, ir;
   logic    accept, pop;
   logic [1:0] push_n;

   // Byte classification.
   always_comb begin
      c_digit  = (req_char_byte >= 8'h30) && (req_char_byte <= 8'h39);
      c_letter = ((req_char_byte >= 8'h61) && (req_char_byte <= 8'h7A)) ||
                 ((req_char_byte >= 8'h41) && (req_char_byte <= 8'h5A));
      c_blank  = (req_char_byte == CHAR_SPACE) || (req_char_byte == CHAR_TAB) ||
                 (req_char_byte == CHAR_VT) || (req_char_byte == CHAR_FEED);
      c_end    = (req_char_byte == CHAR_NUL) || (req_char_byte == CHAR_FF_END);
      c_nl     = (req_char_byte == CHAR_NL);
      c_colon  = (req_char_byte == CHAR_COLON);
      c_point  = (req_char_byte == CHAR_POINT);
      c_under  = (req_char_byte == CHAR_UNDER);
      c_op     = (req_char_byte == CHAR_PLUS) || (req_char_byte == CHAR_MINUS) ||
                 (req_char_byte == CHAR_STAR) || (req_char_byte == CHAR_SLASH);
      // Bytes that close a number; an identifier is also closed by a right paren.
      c_stop   = c_end || c_blank || c_nl || c_op || c_colon ||
                 (req_char_byte == CHAR_LPAREN) || (req_char_byte == CHAR_COMMA);
      c_word   = c_letter || c_digit || c_under;

      single_hit = 1'b1;
      case (req_char_byte)
         CHAR_LPAREN: single_kind = KIND_LPAREN;
         CHAR_RPAREN: single_kind = KIND_RPAREN;
         CHAR_LBRACE: single_kind = KIND_LBRACE;
         CHAR_RBRACE: single_kind = KIND_RBRACE;
         CHAR_PLUS:   single_kind = KIND_PLUS;
         CHAR_MINUS:  single_kind = KIND_MINUS;
         CHAR_SLASH:  single_kind = KIND_DIVIDE;
         CHAR_STAR:   single_kind = KIND_TIMES;
         CHAR_COMMA:  single_kind = KIND_COMMA;
         default: begin
            single_kind = KIND_ERROR;
            single_hit  = 1'b0;
         end
      endcase
   end

   // Saturating counters.
   assign col_adv  = (col_ff == 16'(MAX_COLUMN)) ? col_ff : col_ff + 16'd1;
   assign line_adv = (line_ff == 16'(MAX_LINE)) ? line_ff : line_ff + 16'd1;
   assign len_grow = (len_ff == 8'(MAX_TOKEN_LEN)) ? len_ff : len_ff + 8'd1;

   // Next scanner state and up to two results for the byte at the input.
   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pt_in    = pt_ff;
      do_idle  = 1'b0;
      r0_v     = 1'b0;
      r0       = '{kind: KIND_END, cause: CAUSE_NONE, line: line_ff, column: start_ff,
                   length: len_ff, last: 1'b0};
      ir_v     = 1'b0;
      ir       = '{kind: KIND_END, cause: CAUSE_NONE, line: line_ff, column: col_ff,
                   length: 8'd0, last: 1'b0};

      unique case (mode_ff)
         MODE_NUMBER: begin
            if (c_stop) begin
               r0_v    = 1'b1;
               r0.kind = KIND_NUMBER;
               pt_in   = 1'b0;
               len_in  = 8'd0;
               do_idle = 1'b1;
            end else if (c_digit || (c_point && !pt_ff)) begin
               len_in = len_grow;
               col_in = col_adv;
               if (c_point) begin
                  pt_in = 1'b1;
               end
            end else begin
               r0_v     = 1'b1;
               r0.kind  = KIND_ERROR;
               r0.cause = c_point ? CAUSE_SECOND_PT : CAUSE_BAD_NUMBER;
               r0.length = len_grow;
               col_in   = col_adv;
               mode_in  = MODE_IDLE;
               pt_in    = 1'b0;
               len_in   = 8'd0;
            end
         end
         MODE_IDENT: begin
            if (c_stop || (req_char_byte == CHAR_RPAREN)) begin
               r0_v    = 1'b1;
               r0.kind = KIND_IDENT;
               pt_in   = 1'b0;
               len_in  = 8'd0;
               do_idle = 1'b1;
            end else if (c_word) begin
               len_in = len_grow;
               col_in = col_adv;
            end else begin
               r0_v      = 1'b1;
               r0.kind   = KIND_ERROR;
               r0.cause  = CAUSE_BAD_IDENT;
               r0.length = len_grow;
               col_in    = col_adv;
               mode_in   = MODE_IDLE;
               pt_in     = 1'b0;
               len_in    = 8'd0;
            end
         end
         MODE_COMMENT: begin
            if (c_end || c_nl) begin
               do_idle = 1'b1;
            end else begin
               col_in = col_adv;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      // Idle handling of the byte; the column here is still the byte's own.
      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (c_end) begin
            ir_v = 1'b1;
         end else if (c_blank) begin
            col_in = col_adv;
         end else if (c_nl) begin
            line_in = line_adv;
            col_in  = 16'd1;
         end else if (c_colon) begin
            mode_in = MODE_COMMENT;
            col_in  = col_adv;
         end else if (c_digit || c_point || c_letter || c_under) begin
            mode_in  = (c_digit || c_point) ? MODE_NUMBER : MODE_IDENT;
            start_in = col_ff;
            len_in   = 8'd1;
            pt_in    = c_point;
            col_in   = col_adv;
         end else begin
            ir_v      = 1'b1;
            ir.kind   = single_kind;
            ir.cause  = single_hit ? CAUSE_NONE : CAUSE_BAD_START;
            ir.length = 8'd1;
            col_in    = col_adv;
         end
      end

      // Pack the results in order and mark the final one of the run.
      if (r0_v) begin
         r1_v    = ir_v;
         r1      = ir;
         r1.last = 1'b1;
         r0.last = !ir_v;
      end else begin
         r0_v    = ir_v;
         r0      = ir;
         r0.last = 1'b1;
         r1_v    = 1'b0;
         r1      = ir;
      end
   end

   // Queue control. Input is taken only while two entries are free, so both
   // results of any byte always fit.
   assign req_ready = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = accept ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;

   assign head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
   assign tail_in  = tail_ff + PTR_W'(push_n);
   assign count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= 16'd1;
         col_ff   <= 16'd1;
         start_ff <= 16'd1;
         len_ff   <= 8'd0;
         pt_ff    <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            pt_ff    <= pt_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept && r0_v) begin
         q_ff[tail_ff] <= r0;
      end
      if (accept && r1_v) begin
         q_ff[tail_ff + PTR_W'(1)] <= r1;
      end
   end

   assign rsp_token_kind    = q_ff[head_ff].kind;
   assign rsp_error_cause   = q_ff[head_ff].cause;
   assign rsp_line_number   = q_ff[head_ff].line;
   assign rsp_column_number = q_ff[head_ff].column;
   assign rsp_token_length  = q_ff[head_ff].length;
   assign rsp_last_of_run   = q_ff[head_ff].last;

   // The queue never holds more entries than it has.
   `STTK_CHECK(a_count_bound, count_ff <= CNT_W'(FIFO_DEPTH), "result queue overflow")
   // Line and column counters never fall to zero.
   `STTK_CHECK(a_pos_nonzero, (line_ff != 16'd0) && (col_ff != 16'd0), "position counter is zero")
   // Outside a token no length or point is carried.
   `STTK_CHECK(a_no_token_len,
      !((mode_ff == MODE_IDLE) || (mode_ff == MODE_COMMENT)) || ((len_ff == 8'd0) && !pt_ff),
      "token length kept outside a token")
   // A transferred byte that emits results raises the queue fill unless it drains.
   `STTK_NEXT(a_push_seen, accept && (push_n != 2'd0) && !pop, count_ff != '0,
      "result lost on push")

endmodule

[test/token_checker.sv]
`timescale 1ns / 100ps

module token_checker
   import sttk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_token_kind,
   input  logic [2:0]  rsp_error_cause,
   input  logic [15:0] rsp_line_number,
   input  logic [15:0] rsp_column_number,
   input  logic [7:0]  rsp_token_length,
   input  logic        rsp_last_of_run,
   output int          failures,
   output int          outstanding
);

   // Scanner state as the tokenizer should hold it.
   mode_type    mode;
   logic [15:0] cur_line;
   logic [15:0] cur_column;
   logic [15:0] tok_column;
   logic [7:0]  tok_length;
   logic        tok_has_point;

   rsp_type expected_tokens[$];
   rsp_type step_out[2];
   int      step_count;

   function automatic bit is_end(input logic [7:0] c);
      return c == CHAR_NUL || c == CHAR_FF_END;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FEED;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // Bytes that close a number; an identifier also closes on a right paren.
   function automatic bit is_stop(input logic [7:0] c);
      return is_end(c) || is_blank(c) || c == CHAR_NL || c == CHAR_PLUS ||
             c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH ||
             c == CHAR_LPAREN || c == CHAR_COMMA || c == CHAR_COLON;
   endfunction

   task automatic push_token(input kind_type k, input cause_type c,
                             input logic [15:0] col, input logic [7:0] len);
      step_out[step_count] = '{k, c, cur_line, col, len, 1'b0};
      step_count++;
   endtask

   task automatic bump_column();
      if (cur_column < MAX_COLUMN) cur_column++;
   endtask

   task automatic grow_token();
      if (tok_length < MAX_TOKEN_LEN) tok_length++;
   endtask

   task automatic begin_token(input mode_type m, input logic has_point);
      mode          = m;
      tok_column    = cur_column;
      tok_length    = 8'd1;
      tok_has_point = has_point;
      bump_column();
   endtask

   task automatic idle_scan(input logic [7:0] c);
      kind_type k;
      mode = MODE_IDLE;
      if (is_end(c)) begin
         push_token(KIND_END, CAUSE_NONE, cur_column, 8'd0);
      end else if (is_blank(c)) begin
         bump_column();
      end else if (c == CHAR_NL) begin
         if (cur_line < MAX_LINE) cur_line++;
         cur_column = 16'd1;
      end else if (c == CHAR_COLON) begin
         mode = MODE_COMMENT;
         bump_column();
      end else if (is_digit(c) || c == CHAR_POINT) begin
         begin_token(MODE_NUMBER, c == CHAR_POINT);
      end else if (is_letter(c) || c == CHAR_UNDER) begin
         begin_token(MODE_IDENT, 1'b0);
      end else begin
         case (c)
            CHAR_LPAREN: k = KIND_LPAREN;
            CHAR_RPAREN: k = KIND_RPAREN;
            CHAR_LBRACE: k = KIND_LBRACE;
            CHAR_RBRACE: k = KIND_RBRACE;
            CHAR_PLUS:   k = KIND_PLUS;
            CHAR_MINUS:  k = KIND_MINUS;
            CHAR_SLASH:  k = KIND_DIVIDE;
            CHAR_STAR:   k = KIND_TIMES;
            CHAR_COMMA:  k = KIND_COMMA;
            default:     k = KIND_ERROR;
         endcase
         push_token(k, (k == KIND_ERROR) ? CAUSE_BAD_START : CAUSE_NONE,
                    cur_column, 8'd1);
         bump_column();
      end
   endtask

   // The offending byte is counted in the length and then dropped.
   task automatic token_error(input cause_type c);
      grow_token();
      push_token(KIND_ERROR, c, tok_column, tok_length);
      bump_column();
      mode          = MODE_IDLE;
      tok_has_point = 1'b0;
      tok_length    = 8'd0;
   endtask

   task automatic token_done(input kind_type k, input logic [7:0] c);
      push_token(k, CAUSE_NONE, tok_column, tok_length);
      tok_has_point = 1'b0;
      tok_length    = 8'd0;
      idle_scan(c);
   endtask

   task automatic scan_byte(input logic [7:0] c);
      step_count = 0;
      case (mode)
         MODE_NUMBER: begin
            if (is_stop(c)) begin
               token_done(KIND_NUMBER, c);
            end else if (is_digit(c)) begin
               grow_token();
               bump_column();
            end else if (c == CHAR_POINT) begin
               if (tok_has_point) begin
                  token_error(CAUSE_SECOND_PT);
               end else begin
                  tok_has_point = 1'b1;
                  grow_token();
                  bump_column();
               end
            end else begin
               token_error(CAUSE_BAD_NUMBER);
            end
         end
         MODE_IDENT: begin
            if (is_stop(c) || c == CHAR_RPAREN) begin
               token_done(KIND_IDENT, c);
            end else if (is_letter(c) || is_digit(c) || c == CHAR_UNDER) begin
               grow_token();
               bump_column();
            end else begin
               token_error(CAUSE_BAD_IDENT);
            end
         end
         MODE_COMMENT: begin
            if (is_end(c) || c == CHAR_NL) idle_scan(c);
            else bump_column();
         end
         default: idle_scan(c);
      endcase
      if (step_count > 0) step_out[step_count - 1].last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_out[i]);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // A result can be offered no earlier than the cycle after its byte, so comparing
   // before predicting at the same edge keeps the order right.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode          = MODE_IDLE;
         cur_line      = 16'd1;
         cur_column    = 16'd1;
         tok_column    = 16'd1;
         tok_length    = 8'd0;
         tok_has_point = 1'b0;
         failures      = 0;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected result: kind %0d line %0d column %0d",
                      rsp_token_kind, rsp_line_number, rsp_column_number);
               failures++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_kind", want.kind, rsp_token_kind);
               compare_field("error_cause", want.cause, rsp_error_cause);
               compare_field("line_number", want.line, rsp_line_number);
               compare_field("column_number", want.column, rsp_column_number);
               compare_field("token_length", want.length, rsp_token_length);
               compare_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         if (req_valid && req_ready) scan_byte(req_char_byte);
      end
      outstanding = expected_tokens.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench
   import sttk_pkg::*;
();

   // The run is cut off here.
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_token_kind;
   logic [2:0]  rsp_error_cause;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic [7:0]  rsp_token_length;
   logic        rsp_last_of_run;
   int          failures;
   int          outstanding;

   // Sender pacing. While full_rate is set every byte goes out back to back;
   // sender_steady marks random stretches without gaps.
   bit          full_rate;
   bit          sender_steady;
   int unsigned scanned_items;
   int unsigned cycle_count;

   source_text_tokenizer_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_cause   (rsp_error_cause),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_token_length  (rsp_token_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // The checker sees every transfer on both channels, predicts the tokens
   // and reports how many comparisons failed and how many results are still owed.
   token_checker check_tokens (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_error_cause   (rsp_error_cause),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_token_length  (rsp_token_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one byte and returns at the falling edge after its transfer.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = (full_rate || sender_steady) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_char_byte <= b;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      scanned_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] random_letter();
      return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] ident_char();
      case ($urandom_range(0, 3))
         0, 1:    return random_letter();
         2:       return random_digit();
         default: return CHAR_UNDER;
      endcase
   endfunction

   function automatic logic [7:0] single_char();
      case ($urandom_range(0, 8))
         0:       return CHAR_LPAREN;
         1:       return CHAR_RPAREN;
         2:       return CHAR_LBRACE;
         3:       return CHAR_RBRACE;
         4:       return CHAR_PLUS;
         5:       return CHAR_MINUS;
         6:       return CHAR_SLASH;
         7:       return CHAR_STAR;
         default: return CHAR_COMMA;
      endcase
   endfunction

   // One piece of source text. Most pieces are well formed tokens with random
   // content; simply putting them side by side already produces tokens closed
   // by every kind of terminator as well as tokens broken by a bad byte.
   task automatic send_fragment();
      int unsigned pick;
      int unsigned len;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 12);
      if (pick < 22) begin
         send_byte(($urandom_range(0, 3) == 0) ? CHAR_UNDER : random_letter());
         repeat (len - 1) send_byte(ident_char());
      end else if (pick < 42) begin
         // A point now and then; two in one number is the second point error.
         send_byte(($urandom_range(0, 4) == 0) ? CHAR_POINT : random_digit());
         repeat (len - 1)
            send_byte(($urandom_range(0, 7) == 0) ? CHAR_POINT : random_digit());
      end else if (pick < 58) begin
         send_byte(single_char());
      end else if (pick < 72) begin
         case ($urandom_range(0, 4))
            0:       send_byte(CHAR_SPACE);
            1:       send_byte(CHAR_TAB);
            2:       send_byte(CHAR_VT);
            3:       send_byte(CHAR_FEED);
            default: send_byte(CHAR_NL);
         endcase
      end else if (pick < 78) begin
         // A comment with arbitrary bytes, closed by a newline or end of text.
         send_byte(CHAR_COLON);
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(1, 254));
            send_byte((b == CHAR_NL) ? CHAR_SPACE : b);
         end
         case ($urandom_range(0, 3))
            0:       send_byte(CHAR_NUL);
            1:       send_byte(CHAR_FF_END);
            default: send_byte(CHAR_NL);
         endcase
      end else if (pick < 82) begin
         send_byte($urandom_range(0, 1) ? CHAR_NUL : CHAR_FF_END);
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Result side. Before each transfer it waits a random number of cycles,
   // except in steady stretches. Twice it holds off for a long time so that
   // the result queue fills and the tokenizer stops taking bytes.
   initial begin
      int unsigned taken;
      int unsigned wait_cycles;
      bit          steady;
      rsp_ready = 1'b0;
      taken     = 0;
      steady    = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == 60 || taken == 120) wait_cycles = 300;
         else wait_cycles = steady ? 0 : $urandom_range(0, 9);
         if ($urandom_range(0, 39) == 0) steady = !steady;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Watchdog for a run that hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      req_valid     = 1'b0;
      req_char_byte = 8'd0;
      reset         = 1'b1;
      full_rate     = 1'b0;
      sender_steady = 1'b0;
      scanned_items = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every single character token.
      send_text("(){}+-/*,");
      // A number closed by an operator, then an identifier closed by a right
      // paren: both bytes give two results each.
      send_text("12.5+a_9)");
      // A number that starts with a point and meets a second point.
      send_text(".7.");
      send_byte(CHAR_TAB);
      // A bad byte inside a number, a bad start byte, and a bad byte inside
      // an identifier.
      send_text("4a$b#");
      // Vertical tab and form feed are skipped; a comment runs to the newline.
      send_byte(CHAR_VT);
      send_byte(CHAR_FEED);
      send_text(":c\n");
      // Both end of text codes, one of them closing a number.
      send_byte(CHAR_FF_END);
      send_text("9");
      send_byte(CHAR_NUL);
      // End of text inside a comment also ends the comment.
      send_text(":z");
      send_byte(CHAR_NUL);

      scanned_items = 0;
      while (scanned_items < RANDOM_ITEMS) send_fragment();

      // Saturation, with no gaps on the input side: an identifier and a number
      // both longer than the token length can count.
      full_rate = 1'b1;
      send_byte("q");
      repeat (256) send_byte(ident_char());
      send_byte(CHAR_SPACE);
      send_byte("7");
      repeat (256) send_byte(random_digit());
      send_byte(CHAR_COMMA);
      send_text("ab?");
      send_byte(CHAR_NUL);
      send_text("+z\n-");
      send_byte(CHAR_FF_END);
      req_valid <= 1'b0;

      // Drain, then give a late or extra result the chance to show up.
      do @(negedge clock); while (outstanding != 0);
      repeat (20) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
